>>> rtl/core/icb_pkg.sv
// ----------------------------------------------------------------------------
// I2C slave command buffer package
// Shared types and constants for the command buffer controller and datapath.
// ----------------------------------------------------------------------------
package icb_pkg;

  typedef enum logic [2:0] {
    MODE_ADDR    = 3'd0,
    MODE_RX      = 3'd1,
    MODE_TX      = 3'd2,
    MODE_DESEL   = 3'd3,
    MODE_SERVICE = 3'd4
  } icb_mode_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_EXEC = 1'b1
  } icb_state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } icb_cmd_t;

  localparam int unsigned LimitWidth  = 5;
  localparam int unsigned ChannelByte = 1;
  localparam int unsigned BusyByte    = 7;
  localparam int unsigned ReadyByte   = 8;

  localparam logic [LimitWidth-1:0] LimitReset = 5'd9;

endpackage

>>> rtl/core/i2c_slave_command_buffer.sv
// ----------------------------------------------------------------------------
// I2C slave command buffer
// Event layer of an I2C slave with an auto-incrementing byte command buffer.
//
// Each input transfer carries one bus event or firmware handshake, selected
// by mode_i, and produces exactly one output transfer. Both channels use
// valid and stall: a transfer completes when valid is high and stall is low.
// An event is taken in the idle state, which issues the buffer read, and
// executed in the execute state once the output register is free, so an
// output stall can hold it there; its result is registered on execution
// and then shown with valid until taken. The block holds one event at a
// time and takes no new event until the current one has executed.
// A result that waits under output stall does not block acceptance of the
// next event, which then waits in execution until the result is taken.
// The buffer limit is written through the configuration channel, which is
// always ready. Reset clears the pointer, counters, flags and the written
// flags of the buffer, and sets the limit to nine; no clearing pass is needed.
// ----------------------------------------------------------------------------
module i2c_slave_command_buffer
  import icb_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [LimitWidth-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            mode_i,
  input  logic [7:0]            data_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            tx_data_o,
  output logic [7:0]            byte_count_o,
  output logic [31:0]           transaction_count_o,
  output logic                  got_data_o,
  output logic                  sent_data_o,
  output logic                  service_pending_o,
  output logic [3:0]            mux_channel_o,
  output logic                  mux_update_o
);

  icb_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  icb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  icb_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .mode_i              (mode_i),
    .data_in_i           (data_in_i),
    .tx_data_o           (tx_data_o),
    .byte_count_o        (byte_count_o),
    .transaction_count_o (transaction_count_o),
    .got_data_o          (got_data_o),
    .sent_data_o         (sent_data_o),
    .service_pending_o   (service_pending_o),
    .mux_channel_o       (mux_channel_o),
    .mux_update_o        (mux_update_o)
  );

endmodule

>>> rtl/core/icb_ctrl.sv
// ----------------------------------------------------------------------------
// I2C slave command buffer controller
// Sequences one event at a time and manages the output register handshake.
// ----------------------------------------------------------------------------
module icb_ctrl
  import icb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output icb_cmd_t cmd_o
);

  icb_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      CTRL_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CTRL_EXEC;
        end
      end
      CTRL_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/icb_datapath.sv
// ----------------------------------------------------------------------------
// I2C slave command buffer datapath
// Holds the byte buffer, pointer, counters, flags and the result register.
// ----------------------------------------------------------------------------
module icb_datapath
  import icb_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  icb_cmd_t              cmd_i,
  input  logic                  cfg_we_i,
  input  logic [LimitWidth-1:0] cfg_data_i,
  input  logic [2:0]            mode_i,
  input  logic [7:0]            data_in_i,
  output logic [7:0]            tx_data_o,
  output logic [7:0]            byte_count_o,
  output logic [31:0]           transaction_count_o,
  output logic                  got_data_o,
  output logic                  sent_data_o,
  output logic                  service_pending_o,
  output logic [3:0]            mux_channel_o,
  output logic                  mux_update_o
);

  localparam int unsigned IdxWidth = $clog2(BUF_DEPTH);
  localparam int unsigned CmpWidth =
      ($clog2(BUF_DEPTH + 1) > LimitWidth) ? $clog2(BUF_DEPTH + 1) : LimitWidth;

  logic [7:0]            mem [BUF_DEPTH];
  logic [BUF_DEPTH-1:0]  written_q;
  logic [7:0]            rd_data_q;
  logic                  rd_written_q;
  logic [2:0]            mode_q;
  logic [7:0]            data_q;

  logic [LimitWidth-1:0] limit_q;
  logic [LimitWidth-1:0] ptr_q, ptr_d;
  logic [7:0]            run_cnt_q, run_cnt_d;
  logic                  rx_seen_q, rx_seen_d;
  logic                  tx_seen_q, tx_seen_d;
  logic [7:0]            lat_cnt_q, lat_cnt_d;
  logic [31:0]           txn_cnt_q, txn_cnt_d;
  logic                  lat_rx_q, lat_rx_d;
  logic                  lat_tx_q, lat_tx_d;
  logic                  pending_q, pending_d;
  logic [3:0]            chan_q, chan_d;
  logic [3:0]            chan_src_q, chan_src_d;
  logic [7:0]            busy_q, busy_d;
  logic [7:0]            ready_q, ready_d;
  logic [7:0]            tx_data_q, tx_data_d;
  logic                  upd_q, upd_d;

  logic [CmpWidth-1:0]   ptr_ext;
  logic [IdxWidth-1:0]   addr;
  logic                  in_range;
  logic                  mem_we;
  logic [7:0]            sat_cnt;

  assign ptr_ext  = CmpWidth'(ptr_q);
  assign addr     = ptr_ext[IdxWidth-1:0];
  assign in_range = (ptr_q < limit_q) && (ptr_ext < CmpWidth'(BUF_DEPTH));
  assign sat_cnt  = (run_cnt_q == 8'hFF) ? run_cnt_q : run_cnt_q + 8'd1;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_data_q    <= mem[addr];
      rd_written_q <= written_q[addr];
      mode_q       <= mode_i;
      data_q       <= data_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      tx_data_q <= tx_data_d;
    end
  end

  always_comb begin
    ptr_d      = ptr_q;
    run_cnt_d  = run_cnt_q;
    rx_seen_d  = rx_seen_q;
    tx_seen_d  = tx_seen_q;
    lat_cnt_d  = lat_cnt_q;
    txn_cnt_d  = txn_cnt_q;
    lat_rx_d   = lat_rx_q;
    lat_tx_d   = lat_tx_q;
    pending_d  = pending_q;
    chan_d     = chan_q;
    chan_src_d = chan_src_q;
    busy_d     = busy_q;
    ready_d    = ready_q;
    tx_data_d  = 8'h00;
    upd_d      = 1'b0;
    mem_we     = 1'b0;
    unique case (mode_q)
      MODE_ADDR: begin
        ptr_d     = '0;
        run_cnt_d = '0;
        rx_seen_d = 1'b0;
        tx_seen_d = 1'b0;
      end
      MODE_RX: begin
        if (in_range) begin
          mem_we = cmd_i.commit;
          ptr_d  = ptr_q + LimitWidth'(1);
          if (ptr_ext == CmpWidth'(ChannelByte)) begin
            chan_src_d = data_q[3:0];
          end
          if (ptr_ext == CmpWidth'(BusyByte)) begin
            busy_d = data_q;
          end
          if (ptr_ext == CmpWidth'(ReadyByte)) begin
            ready_d = data_q;
          end
        end
        run_cnt_d = sat_cnt;
        rx_seen_d = 1'b1;
      end
      MODE_TX: begin
        if (in_range) begin
          ptr_d = ptr_q + LimitWidth'(1);
          if (ptr_ext == CmpWidth'(BusyByte)) begin
            tx_data_d = busy_q;
          end else if (ptr_ext == CmpWidth'(ReadyByte)) begin
            tx_data_d = ready_q;
          end else begin
            tx_data_d = rd_written_q ? rd_data_q : 8'h00;
          end
        end else begin
          tx_data_d = 8'hFF;
        end
        run_cnt_d = sat_cnt;
        tx_seen_d = 1'b1;
      end
      MODE_DESEL: begin
        lat_cnt_d = run_cnt_q;
        txn_cnt_d = txn_cnt_q + 32'd1;
        lat_rx_d  = rx_seen_q;
        lat_tx_d  = tx_seen_q;
        pending_d = rx_seen_q;
        if (rx_seen_q) begin
          busy_d  = 8'd1;
          ready_d = 8'd0;
        end
      end
      MODE_SERVICE: begin
        if (pending_q) begin
          chan_d    = chan_src_q;
          upd_d     = 1'b1;
          pending_d = 1'b0;
          busy_d    = 8'd0;
          ready_d   = 8'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      ptr_q      <= '0;
      run_cnt_q  <= '0;
      rx_seen_q  <= 1'b0;
      tx_seen_q  <= 1'b0;
      lat_cnt_q  <= '0;
      txn_cnt_q  <= '0;
      lat_rx_q   <= 1'b0;
      lat_tx_q   <= 1'b0;
      pending_q  <= 1'b0;
      chan_q     <= '0;
      chan_src_q <= '0;
      busy_q     <= '0;
      ready_q    <= '0;
      upd_q      <= 1'b0;
    end else if (cmd_i.commit) begin
      if (mem_we) begin
        written_q[addr] <= 1'b1;
      end
      ptr_q      <= ptr_d;
      run_cnt_q  <= run_cnt_d;
      rx_seen_q  <= rx_seen_d;
      tx_seen_q  <= tx_seen_d;
      lat_cnt_q  <= lat_cnt_d;
      txn_cnt_q  <= txn_cnt_d;
      lat_rx_q   <= lat_rx_d;
      lat_tx_q   <= lat_tx_d;
      pending_q  <= pending_d;
      chan_q     <= chan_d;
      chan_src_q <= chan_src_d;
      busy_q     <= busy_d;
      ready_q    <= ready_d;
      upd_q      <= upd_d;
    end
  end

  assign tx_data_o           = tx_data_q;
  assign byte_count_o        = lat_cnt_q;
  assign transaction_count_o = txn_cnt_q;
  assign got_data_o          = lat_rx_q;
  assign sent_data_o         = lat_tx_q;
  assign service_pending_o   = pending_q;
  assign mux_channel_o       = chan_q;
  assign mux_update_o        = upd_q;

endmodule
